@@ design/bqrl_pkg.sv @@
`default_nettype none

package bqrl_pkg;

    localparam int QLIM_W     = 7;
    localparam int PPS_W      = 16;
    localparam int BPS_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TAG_W      = 16;
    localparam int BYTES_W    = 16;
    localparam int EV_W       = 3;
    localparam int PKTS_LEFT_W  = 17;
    localparam int BYTES_LEFT_W = 25;
    localparam int MAX_RESULTS  = 64;
    localparam int NRES_W       = 7;

    localparam logic [QLIM_W-1:0] QUEUE_LIMIT_RST = 7'd64;
    localparam logic [PPS_W-1:0]  PPS_RST         = 16'd36;
    localparam logic [BPS_W-1:0]  BPS_RST         = 24'd256000;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PPS         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BPS         = 2'd2;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_BYPASS    = 3'd0,
        EV_QUEUED    = 3'd1,
        EV_DROPPED   = 3'd2,
        EV_SENT      = 3'd3,
        EV_DISCARDED = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TK_CHK0,
        ST_TK_EV,
        ST_TK_CHK
    } state_t;

    typedef struct packed {
        logic offer;
        logic tick_start;
        logic rd_issue;
        logic capture;
        logic emit;
        logic last;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/broadcast_queue_rate_limiter_top.sv @@
`default_nettype none

// Broadcast queue rate limiter. An offer is taken while no tick is in progress
// and the output register is free or being emptied, and its single result
// appears on the next cycle, so offers stream at one per cycle under a ready
// sink. A tick holds the input while packets are released from the FIFO (at
// most 64 per tick), each through the registered read of the FIFO memory
// followed by a budget check, and longer while the result side stalls. A tick
// that releases nothing gives no result. The FIFO memory needs no clearing
// pass after reset; the block is ready as soon as reset is released.
module broadcast_queue_rate_limiter_top #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int TICKS_PER_SECOND = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bqrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bqrl_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_command,
    input  wire logic                            s_is_broadcast,
    input  wire logic [bqrl_pkg::BYTES_W-1:0]    s_packet_bytes,
    input  wire logic [bqrl_pkg::TAG_W-1:0]      s_packet_tag,
    input  wire logic                            s_dest_active,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bqrl_pkg::EV_W-1:0]            m_event_res,
    output logic [bqrl_pkg::TAG_W-1:0]           m_out_tag,
    output logic [bqrl_pkg::BYTES_W-1:0]         m_out_bytes,
    output logic                                 m_last
);

    bqrl_pkg::ctrl_cmd_t cmd;
    bqrl_pkg::dp_stat_t  stat;

    bqrl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bqrl_datapath #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_is_broadcast (s_is_broadcast),
        .s_packet_bytes (s_packet_bytes),
        .s_packet_tag   (s_packet_tag),
        .s_dest_active  (s_dest_active),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_out_tag      (m_out_tag),
        .m_out_bytes    (m_out_bytes),
        .m_last         (m_last)
    );

    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register busy");

    // a tick transfer makes the block busy on the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == bqrl_pkg::CMD_TICK) |=> !s_ready)
        else $error("input ready right after tick transfer");

    // an entry is captured only in the cycle after its memory read
    a_capture_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> $past(cmd.rd_issue))
        else $error("capture without preceding FIFO read");

endmodule

`default_nettype wire

@@ design/bqrl_ctrl.sv @@
`default_nettype none

module bqrl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_command,
    output logic                   s_ready,
    input  wire bqrl_pkg::dp_stat_t stat,
    output bqrl_pkg::ctrl_cmd_t    cmd
);

    bqrl_pkg::state_t state_reg;
    bqrl_pkg::state_t state_next;
    logic             take;

    assign take = s_valid && stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bqrl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bqrl_pkg::ST_IDLE: begin
                if (take && s_command == bqrl_pkg::CMD_TICK) begin
                    state_next = bqrl_pkg::ST_TK_CHK0;
                end
            end
            bqrl_pkg::ST_TK_CHK0: begin
                state_next = stat.more ? bqrl_pkg::ST_TK_EV : bqrl_pkg::ST_IDLE;
            end
            bqrl_pkg::ST_TK_EV: begin
                state_next = bqrl_pkg::ST_TK_CHK;
            end
            bqrl_pkg::ST_TK_CHK: begin
                if (stat.out_free) begin
                    state_next = stat.more ? bqrl_pkg::ST_TK_EV : bqrl_pkg::ST_IDLE;
                end
            end
            default: state_next = bqrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            bqrl_pkg::ST_IDLE: begin
                s_ready = stat.out_free;
                if (take) begin
                    cmd.offer      = (s_command == bqrl_pkg::CMD_OFFER);
                    cmd.tick_start = (s_command == bqrl_pkg::CMD_TICK);
                end
            end
            bqrl_pkg::ST_TK_CHK0: begin
                cmd.rd_issue = stat.more;
                cmd.finish   = !stat.more;
            end
            bqrl_pkg::ST_TK_EV: begin
                cmd.capture = 1'b1;
            end
            bqrl_pkg::ST_TK_CHK: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.last     = !stat.more;
                    cmd.rd_issue = stat.more;
                    cmd.finish   = !stat.more;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/bqrl_datapath.sv @@
`default_nettype none

module bqrl_datapath #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int TICKS_PER_SECOND = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bqrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bqrl_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                                s_is_broadcast,
    input  wire logic [bqrl_pkg::BYTES_W-1:0]        s_packet_bytes,
    input  wire logic [bqrl_pkg::TAG_W-1:0]          s_packet_tag,
    input  wire logic                                s_dest_active,
    input  wire bqrl_pkg::ctrl_cmd_t                 cmd,
    output bqrl_pkg::dp_stat_t                       stat,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [bqrl_pkg::EV_W-1:0]                m_event_res,
    output logic [bqrl_pkg::TAG_W-1:0]               m_out_tag,
    output logic [bqrl_pkg::BYTES_W-1:0]             m_out_bytes,
    output logic                                     m_last
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W  = (CNT_W > bqrl_pkg::QLIM_W) ? CNT_W : bqrl_pkg::QLIM_W;
    localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);

    // divide by TICKS_PER_SECOND as a multiply by a rounded-up reciprocal
    localparam int DIV_SH = bqrl_pkg::BPS_W + $clog2(TICKS_PER_SECOND);
    localparam int RCP_W  = bqrl_pkg::BPS_W + 1;
    localparam int PROD_W = DIV_SH + bqrl_pkg::BPS_W;
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((64'd1 << DIV_SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));

    typedef struct packed {
        logic [bqrl_pkg::TAG_W-1:0]   tag;
        logic [bqrl_pkg::BYTES_W-1:0] bytes;
        logic                         active;
    } entry_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic   mem_we;

    logic [bqrl_pkg::QLIM_W-1:0] qlimit_reg, qlimit_next;
    logic [bqrl_pkg::PPS_W-1:0]  pps_reg, pps_next;
    logic [bqrl_pkg::BPS_W-1:0]  bps_reg, bps_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic signed [bqrl_pkg::PKTS_LEFT_W-1:0]  pkts_left_reg, pkts_left_next;
    logic signed [bqrl_pkg::BYTES_LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;

    logic [bqrl_pkg::PPS_W-1:0]               pak_budget_reg, pak_budget_next;
    logic signed [bqrl_pkg::BYTES_LEFT_W-1:0] byte_budget_reg, byte_budget_next;
    logic [bqrl_pkg::NRES_W-1:0]              nres_reg, nres_next;

    bqrl_pkg::event_t             pend_ev_reg, pend_ev_next;
    logic [bqrl_pkg::TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic [bqrl_pkg::BYTES_W-1:0] pend_bytes_reg, pend_bytes_next;

    logic                         out_valid_reg, out_valid_next;
    bqrl_pkg::event_t             out_ev_reg, out_ev_next;
    logic [bqrl_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic [bqrl_pkg::BYTES_W-1:0] out_bytes_reg, out_bytes_next;
    logic                         out_last_reg, out_last_next;

    logic [LIM_W-1:0]             limit;
    logic [PROD_W-1:0]            pps_prod;
    logic [PROD_W-1:0]            bps_prod;
    logic [bqrl_pkg::PPS_W-1:0]   pak_div;
    logic [bqrl_pkg::BPS_W-1:0]   bps_div;
    logic signed [bqrl_pkg::BYTES_LEFT_W-1:0] ent_bytes_s;

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] i);
        return (i == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    always_comb begin
        if (LIM_W'(qlimit_reg) > LIM_W'(QUEUE_DEPTH)) begin
            limit = LIM_W'(QUEUE_DEPTH);
        end else begin
            limit = LIM_W'(qlimit_reg);
        end
    end

    assign pps_prod    = PROD_W'(pps_reg) * PROD_W'(DIV_RCP);
    assign bps_prod    = PROD_W'(bps_reg) * PROD_W'(DIV_RCP);
    assign pak_div     = pps_prod[DIV_SH +: bqrl_pkg::PPS_W];
    assign bps_div     = bps_prod[DIV_SH +: bqrl_pkg::BPS_W];
    assign ent_bytes_s = $signed({{(bqrl_pkg::BYTES_LEFT_W - bqrl_pkg::BYTES_W){1'b0}},
                                  rd_data_reg.bytes});

    assign stat.out_free = !out_valid_reg || m_ready;
    assign stat.more     = (pak_budget_reg != '0) && (byte_budget_reg > 0)
                           && (pkts_left_reg > 0) && (bytes_left_reg > 0)
                           && (count_reg != '0)
                           && (nres_reg < bqrl_pkg::NRES_W'(bqrl_pkg::MAX_RESULTS));

    always_comb begin
        qlimit_next      = qlimit_reg;
        pps_next         = pps_reg;
        bps_next         = bps_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        pkts_left_next   = pkts_left_reg;
        bytes_left_next  = bytes_left_reg;
        ticks_next       = ticks_reg;
        pak_budget_next  = pak_budget_reg;
        byte_budget_next = byte_budget_reg;
        nres_next        = nres_reg;
        pend_ev_next     = pend_ev_reg;
        pend_tag_next    = pend_tag_reg;
        pend_bytes_next  = pend_bytes_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_ev_next      = out_ev_reg;
        out_tag_next     = out_tag_reg;
        out_bytes_next   = out_bytes_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                bqrl_pkg::REG_QUEUE_LIMIT: qlimit_next = cfg_wr_data[bqrl_pkg::QLIM_W-1:0];
                bqrl_pkg::REG_PPS:         pps_next    = cfg_wr_data[bqrl_pkg::PPS_W-1:0];
                bqrl_pkg::REG_BPS:         bps_next    = cfg_wr_data[bqrl_pkg::BPS_W-1:0];
                default: ;
            endcase
        end

        if (cmd.offer) begin
            out_valid_next = 1'b1;
            out_tag_next   = s_packet_tag;
            out_bytes_next = s_packet_bytes;
            out_last_next  = 1'b1;
            if (!s_is_broadcast) begin
                out_ev_next = bqrl_pkg::EV_BYPASS;
            end else if (LIM_W'(count_reg) < limit) begin
                mem_we      = 1'b1;
                tail_next   = next_index(tail_reg);
                count_next  = count_reg + 1'b1;
                out_ev_next = bqrl_pkg::EV_QUEUED;
            end else begin
                out_ev_next = bqrl_pkg::EV_DROPPED;
            end
        end

        if (cmd.tick_start) begin
            pak_budget_next  = (pak_div == '0) ? bqrl_pkg::PPS_W'(1) : pak_div;
            byte_budget_next = $signed({1'b0, bps_div});
            nres_next        = '0;
        end

        if (cmd.rd_issue) begin
            head_next  = next_index(head_reg);
            count_next = count_reg - 1'b1;
        end

        if (cmd.capture) begin
            nres_next       = nres_reg + 1'b1;
            pend_tag_next   = rd_data_reg.tag;
            pend_bytes_next = rd_data_reg.bytes;
            if (rd_data_reg.active) begin
                pend_ev_next     = bqrl_pkg::EV_SENT;
                byte_budget_next = byte_budget_reg - ent_bytes_s;
                pak_budget_next  = pak_budget_reg - 1'b1;
                pkts_left_next   = pkts_left_reg - bqrl_pkg::PKTS_LEFT_W'(1);
                bytes_left_next  = bytes_left_reg - ent_bytes_s;
            end else begin
                pend_ev_next = bqrl_pkg::EV_DISCARDED;
            end
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_ev_next    = pend_ev_reg;
            out_tag_next   = pend_tag_reg;
            out_bytes_next = pend_bytes_reg;
            out_last_next  = cmd.last;
        end

        if (cmd.finish) begin
            if (ticks_reg <= TICK_W'(1)) begin
                ticks_next      = TICK_W'(TICKS_PER_SECOND);
                pkts_left_next  = $signed({1'b0, pps_reg});
                bytes_left_next = $signed({1'b0, bps_reg});
            end else begin
                ticks_next = ticks_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= '{tag: s_packet_tag, bytes: s_packet_bytes, active: s_dest_active};
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlimit_reg     <= bqrl_pkg::QUEUE_LIMIT_RST;
            pps_reg        <= bqrl_pkg::PPS_RST;
            bps_reg        <= bqrl_pkg::BPS_RST;
            count_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pkts_left_reg  <= $signed({1'b0, bqrl_pkg::PPS_RST});
            bytes_left_reg <= $signed({1'b0, bqrl_pkg::BPS_RST});
            ticks_reg      <= TICK_W'(TICKS_PER_SECOND);
            out_valid_reg  <= 1'b0;
        end else begin
            qlimit_reg     <= qlimit_next;
            pps_reg        <= pps_next;
            bps_reg        <= bps_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pkts_left_reg  <= pkts_left_next;
            bytes_left_reg <= bytes_left_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pak_budget_reg  <= pak_budget_next;
        byte_budget_reg <= byte_budget_next;
        nres_reg        <= nres_next;
        pend_ev_reg     <= pend_ev_next;
        pend_tag_reg    <= pend_tag_next;
        pend_bytes_reg  <= pend_bytes_next;
        out_ev_reg      <= out_ev_next;
        out_tag_reg     <= out_tag_next;
        out_bytes_reg   <= out_bytes_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_event_res = out_ev_reg;
    assign m_out_tag   = out_tag_reg;
    assign m_out_bytes = out_bytes_reg;
    assign m_last      = out_last_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int QDEPTH        = 64;
    localparam int TICKS_PER_SEC = 4;
    localparam int SETTLE_LIMIT  = 20000;

    typedef struct {
        logic [bqrl_pkg::TAG_W-1:0]   tag;
        logic [bqrl_pkg::BYTES_W-1:0] nbytes;
        logic                         act;
    } bq_entry_t;

    typedef struct {
        bqrl_pkg::event_t             ev;
        logic [bqrl_pkg::TAG_W-1:0]   tag;
        logic [bqrl_pkg::BYTES_W-1:0] nbytes;
        logic                         fin;
    } bq_result_t;

    class bq_scoreboard;
        int unsigned qlim;
        int unsigned pps;
        int unsigned bps;
        bq_entry_t   fifo_q[$];
        int          pkts_left;
        int          bytes_left;
        int          ticks_left;
        bq_result_t  expected_q[$];
        int          errors;
        int          n_offers;
        int          n_ticks;
        int          n_checked;
        int          n_sent;
        int          n_dropped;
        int          n_discarded;
        int          n_settings;

        function new();
            qlim        = bqrl_pkg::QUEUE_LIMIT_RST;
            pps         = bqrl_pkg::PPS_RST;
            bps         = bqrl_pkg::BPS_RST;
            pkts_left   = bqrl_pkg::PPS_RST;
            bytes_left  = bqrl_pkg::BPS_RST;
            ticks_left  = TICKS_PER_SEC;
            errors      = 0;
            n_offers    = 0;
            n_ticks     = 0;
            n_checked   = 0;
            n_sent      = 0;
            n_dropped   = 0;
            n_discarded = 0;
            n_settings  = 0;
        endfunction

        function void write_reg(logic [bqrl_pkg::CFG_IDX_W-1:0] idx,
                                logic [bqrl_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bqrl_pkg::REG_QUEUE_LIMIT: qlim = val[bqrl_pkg::QLIM_W-1:0];
                bqrl_pkg::REG_PPS:         pps  = val[bqrl_pkg::PPS_W-1:0];
                bqrl_pkg::REG_BPS:         bps  = val[bqrl_pkg::BPS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_transfer(logic cmd, logic bc, logic [bqrl_pkg::BYTES_W-1:0] nb,
                                    logic [bqrl_pkg::TAG_W-1:0] tg, logic act);
            int unsigned limit;
            int          pak;
            int          bb;
            bq_entry_t   ent;
            bq_result_t  r;
            bq_result_t  burst[$];
            if (cmd == bqrl_pkg::CMD_OFFER) begin
                n_offers++;
                limit = (qlim > QDEPTH) ? QDEPTH : qlim;
                r.tag = tg;
                r.nbytes = nb;
                r.fin = 1'b1;
                if (!bc) begin
                    r.ev = bqrl_pkg::EV_BYPASS;
                end else if (fifo_q.size() < limit) begin
                    ent.tag = tg;
                    ent.nbytes = nb;
                    ent.act = act;
                    fifo_q.push_back(ent);
                    r.ev = bqrl_pkg::EV_QUEUED;
                end else begin
                    r.ev = bqrl_pkg::EV_DROPPED;
                    n_dropped++;
                end
                expected_q.push_back(r);
            end else begin
                n_ticks++;
                pak = pps / TICKS_PER_SEC;
                if (pak == 0) pak = 1;
                bb = bps / TICKS_PER_SEC;
                while (pak > 0 && bb > 0 && pkts_left > 0 && bytes_left > 0 &&
                       fifo_q.size() > 0 && burst.size() < bqrl_pkg::MAX_RESULTS) begin
                    ent = fifo_q.pop_front();
                    r.tag = ent.tag;
                    r.nbytes = ent.nbytes;
                    r.fin = 1'b0;
                    if (!ent.act) begin
                        r.ev = bqrl_pkg::EV_DISCARDED;
                        n_discarded++;
                    end else begin
                        bb -= int'(ent.nbytes);
                        pak--;
                        pkts_left--;
                        bytes_left -= int'(ent.nbytes);
                        r.ev = bqrl_pkg::EV_SENT;
                        n_sent++;
                    end
                    burst.push_back(r);
                end
                if (ticks_left > 0) ticks_left--;
                if (ticks_left == 0) begin
                    ticks_left = TICKS_PER_SEC;
                    pkts_left  = pps;
                    bytes_left = bps;
                end
                if (burst.size() > 0) burst[burst.size()-1].fin = 1'b1;
                foreach (burst[i]) expected_q.push_back(burst[i]);
            end
        endfunction

        function void check_result(logic [bqrl_pkg::EV_W-1:0] ev, logic [bqrl_pkg::TAG_W-1:0] tg,
                                   logic [bqrl_pkg::BYTES_W-1:0] nb, logic fin);
            bq_result_t e;
            n_checked++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result ev=%0d tag=%0h bytes=%0h last=%0b",
                         $time, ev, tg, nb, fin);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (ev !== e.ev) begin
                $display("%0t: event_res expected %0d actual %0d", $time, e.ev, ev);
                errors++;
            end
            if (tg !== e.tag) begin
                $display("%0t: out_tag expected %0h actual %0h", $time, e.tag, tg);
                errors++;
            end
            if (nb !== e.nbytes) begin
                $display("%0t: out_bytes expected %0h actual %0h", $time, e.nbytes, nb);
                errors++;
            end
            if (fin !== e.fin) begin
                $display("%0t: last expected %0b actual %0b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            cfg_wr_en      = 1'b0;
    logic [bqrl_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [bqrl_pkg::CFG_DATA_W-1:0] cfg_wr_data    = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic                            s_command      = bqrl_pkg::CMD_OFFER;
    logic                            s_is_broadcast = 1'b0;
    logic [bqrl_pkg::BYTES_W-1:0]    s_packet_bytes = '0;
    logic [bqrl_pkg::TAG_W-1:0]      s_packet_tag   = '0;
    logic                            s_dest_active  = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [bqrl_pkg::EV_W-1:0]       m_event_res;
    logic [bqrl_pkg::TAG_W-1:0]      m_out_tag;
    logic [bqrl_pkg::BYTES_W-1:0]    m_out_bytes;
    logic                            m_last;

    bit           gaps_on = 1'b1;
    bq_scoreboard sb;

    broadcast_queue_rate_limiter_top #(
        .QUEUE_DEPTH      (QDEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SEC)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_is_broadcast (s_is_broadcast),
        .s_packet_bytes (s_packet_bytes),
        .s_packet_tag   (s_packet_tag),
        .s_dest_active  (s_dest_active),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_out_tag      (m_out_tag),
        .m_out_bytes    (m_out_bytes),
        .m_last         (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic push_item(input logic cmd, input logic bc,
                             input logic [bqrl_pkg::BYTES_W-1:0] nb,
                             input logic [bqrl_pkg::TAG_W-1:0] tg, input logic act);
        while (gaps_on && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_is_broadcast <= bc;
        s_packet_bytes <= nb;
        s_packet_tag   <= tg;
        s_dest_active  <= act;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_transfer(cmd, bc, nb, tg, act);
    endtask

    task automatic offer(input logic bc, input logic [bqrl_pkg::BYTES_W-1:0] nb,
                         input logic [bqrl_pkg::TAG_W-1:0] tg, input logic act);
        push_item(bqrl_pkg::CMD_OFFER, bc, nb, tg, act);
    endtask

    // payload of a tick is don't-care; randomize it anyway
    task automatic tick();
        push_item(bqrl_pkg::CMD_TICK, 1'($urandom_range(1)), bqrl_pkg::BYTES_W'($urandom),
                  bqrl_pkg::TAG_W'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic rand_item();
        int                           sel;
        logic [bqrl_pkg::BYTES_W-1:0] nb;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 14) begin
            tick();
        end else begin
            if (sel < 10)      nb = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            else if (sel < 60) nb = bqrl_pkg::BYTES_W'($urandom_range(1500, 40));
            else               nb = bqrl_pkg::BYTES_W'($urandom);
            offer($urandom_range(99) < 65, nb, bqrl_pkg::TAG_W'($urandom),
                  $urandom_range(99) < 80);
        end
    endtask

    // drain: wait until all expected results arrived (or SETTLE_LIMIT runs out), then let a silent tick finish
    task automatic settle();
        int cnt;
        cnt = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0 && cnt < SETTLE_LIMIT) begin
            @(posedge aclk);
            cnt++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [bqrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bqrl_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(input int unsigned ql, input int unsigned pp, input int unsigned bp);
        settle();
        write_cfg(bqrl_pkg::REG_QUEUE_LIMIT, bqrl_pkg::CFG_DATA_W'(ql));
        write_cfg(bqrl_pkg::REG_PPS, bqrl_pkg::CFG_DATA_W'(pp));
        write_cfg(bqrl_pkg::REG_BPS, bqrl_pkg::CFG_DATA_W'(bp));
        sb.n_settings++;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready)
                    sb.check_result(m_event_res, m_out_tag, m_out_bytes, m_last);
                if (!gaps_on || $urandom_range(99) >= 37) m_ready <= 1'b1;
                else                                     m_ready <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** broadcast_queue_rate_limiter_top: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset register values
        offer(1'b0, 16'h0000, 16'h0000, 1'b0);
        offer(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        offer(1'b1, 16'hFFFF, 16'h0001, 1'b1);
        offer(1'b1, 16'd100,  16'h0002, 1'b0);
        offer(1'b1, 16'd200,  16'h0003, 1'b1);
        tick();
        tick();
        tick();
        tick();

        set_regs(0, bqrl_pkg::PPS_RST, bqrl_pkg::BPS_RST);
        offer(1'b1, 16'd64, 16'h00A0, 1'b1);
        set_regs(127, bqrl_pkg::PPS_RST, bqrl_pkg::BPS_RST);
        offer(1'b1, 16'd64, 16'h00A1, 1'b1);
        offer(1'b1, 16'd64, 16'h00A2, 1'b0);
        set_regs(1, 0, 3);
        write_cfg(2'd3, 24'hFFFFFF);
        offer(1'b1, 16'd64, 16'h00A3, 1'b1);
        tick();
        tick();
        tick();
        tick();
        set_regs(1, 0, 24'hFFFFFF);
        tick();
        set_regs(1, 1, 24'hFFFFFF);
        tick();
        tick();
        tick();
        tick();
        tick();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(bqrl_pkg::QUEUE_LIMIT_RST, bqrl_pkg::PPS_RST, bqrl_pkg::BPS_RST);
                1: set_regs($urandom_range(64, 1), $urandom_range(200, 4),
                            $urandom_range(400000, 1000));
                2: set_regs(127, 65535, 24'hFFFFFF);
                3: set_regs(1, 3, 6000);
                4: set_regs(0, $urandom_range(65535, 1), $urandom_range(24'hFFFFFF, 1));
                5: set_regs($urandom_range(127), $urandom_range(65535, 1),
                            $urandom_range(24'hFFFFFF, 1));
                6: set_regs(8, 0, 4);
                default: set_regs($urandom_range(127), $urandom_range(65535),
                                  $urandom_range(24'hFFFFFF));
            endcase
            gaps_on = !(ph == 2 || ph == 3);
            for (int k = 0; k < 18; k++) begin
                if (ph == 1 && k == 10) settle();
                rand_item();
            end
        end
        gaps_on = 1'b1;

        settle();
        repeat (20) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
            sb.errors++;
        end
        $display("Run covered %0d offers and %0d ticks over %0d register settings.",
                 sb.n_offers, sb.n_ticks, sb.n_settings);
        $display("Checked %0d results: %0d sent, %0d dropped full, %0d discarded inactive.",
                 sb.n_checked, sb.n_sent, sb.n_dropped, sb.n_discarded);
        if (sb.errors == 0) begin
            $display("** broadcast_queue_rate_limiter_top: PASSED **");
        end else begin
            $display("** broadcast_queue_rate_limiter_top: FAILED **");
        end
        $finish;
    end

endmodule
